// ===== rtl/hlrc_pkg.sv =====
// ---------------------------------------------------------------------------
// Hatch line rectangle clipper: shared types and constants
// Field widths, register codes, line kinds and the saturation helper used by
// the stages of the clipper pipeline.
// ---------------------------------------------------------------------------
package hlrc_pkg;

	localparam int CoordW  = 32;                 // signed Q15.16 coordinate
	localparam int DimW    = 31;                 // unsigned Q15.16 size / pitch
	localparam int IndexW  = 16;                 // signed line index
	localparam int FracW   = 16;                 // fraction bits
	localparam int ModeW   = 2;
	localparam int RegIdxW = 3;
	localparam int OffsW   = DimW + IndexW + 1;  // pitch * index
	localparam int KwRawW  = CoordW + DimW;      // slope * half width, unscaled
	localparam int KwW     = KwRawW - FracW;     // slope * half width, Q15.16
	localparam int SumW    = OffsW + 1;          // offset +/- size terms
	localparam int SplitW  = 24;                 // low slice of the intercept operand
	localparam int ArgHiW  = SumW - SplitW;      // signed high slice
	localparam int PartW   = ArgHiW + CoordW;    // one partial product
	localparam int ProdW   = PartW + SplitW;     // full intercept product
	localparam int SatInW  = ProdW - FracW;      // widest value fed to saturation

	localparam logic [ModeW-1:0] MODE_SLOPED = 2'd0;
	localparam logic [ModeW-1:0] MODE_HORIZ  = 2'd1;

	localparam logic [RegIdxW-1:0] REG_MODE      = 3'd0;
	localparam logic [RegIdxW-1:0] REG_SLOPE     = 3'd1;
	localparam logic [RegIdxW-1:0] REG_INV_SLOPE = 3'd2;
	localparam logic [RegIdxW-1:0] REG_HALF_W    = 3'd3;
	localparam logic [RegIdxW-1:0] REG_HALF_H    = 3'd4;
	localparam logic [RegIdxW-1:0] REG_PITCH     = 3'd5;

	localparam logic [CoordW-1:0] UNITY_Q16 = 32'h0001_0000;

	typedef enum logic [2:0] {
		KIND_HORIZ,
		KIND_VERT,
		KIND_SHALLOW_POS,
		KIND_STEEP_POS,
		KIND_STEEP_NEG,
		KIND_SHALLOW_NEG
	} line_kind_t;

	typedef struct packed {
		logic [ModeW-1:0]         mode;
		logic signed [CoordW-1:0] slope;
		logic signed [CoordW-1:0] inv_slope;
		logic [DimW-1:0]          half_width;
		logic [DimW-1:0]          half_height;
		logic [DimW-1:0]          line_pitch;
	} cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// yp = kw + o, yn = o - kw, compared with the rectangle's top and bottom
	typedef struct packed {
		logic yp_ge_h;
		logic yp_gt_nh;
		logic yp_lt_nh;
		logic yn_le_nh;
		logic yn_lt_h;
		logic yn_gt_h;
	} edge_flags_t;

	function automatic logic signed [CoordW-1:0] sat_coord(
		input logic signed [SatInW-1:0] v
	);
		if ((&v[SatInW-1:CoordW-1]) || !(|v[SatInW-1:CoordW-1])) begin
			return v[CoordW-1:0];
		end else if (v[SatInW-1]) begin
			return {1'b1, {(CoordW-1){1'b0}}};
		end else begin
			return {1'b0, {(CoordW-1){1'b1}}};
		end
	endfunction

endpackage

// ===== rtl/hlrc_front.sv =====
// ---------------------------------------------------------------------------
// Hatch line clipper: front stages
// Stage 1 forms the line offset and the unscaled slope-width product; stage 2
// classifies the line and prepares the intercept operands.
// ---------------------------------------------------------------------------
module hlrc_front (
	input  logic                                 clk,
	input  hlrc_pkg::stage_en_t                  en,
	input  hlrc_pkg::cfg_t                       cfg,
	input  logic signed [hlrc_pkg::IndexW-1:0]   line_index,
	output logic signed [hlrc_pkg::OffsW-1:0]    o_s2,
	output logic signed [hlrc_pkg::KwW-1:0]      kw_s2,
	output hlrc_pkg::line_kind_t                 kind_s2,
	output logic signed [hlrc_pkg::SumW-1:0]     a_top_s2,
	output logic signed [hlrc_pkg::SumW-1:0]     a_bot_s2
);

	logic signed [hlrc_pkg::OffsW-1:0]  o_mul;
	logic signed [hlrc_pkg::KwRawW-1:0] kw_mul;
	logic signed [hlrc_pkg::OffsW-1:0]  o_s1;
	logic signed [hlrc_pkg::KwRawW-1:0] kw_raw_s1;
	logic signed [hlrc_pkg::KwRawW-1:0] h_raw;
	logic signed [hlrc_pkg::KwRawW-1:0] neg_h_raw;
	logic signed [hlrc_pkg::SumW-1:0]   h_ext;
	logic signed [hlrc_pkg::SumW-1:0]   o_ext;
	hlrc_pkg::line_kind_t               kind_d;

	assign o_mul  = $signed({1'b0, cfg.line_pitch}) * line_index;
	assign kw_mul = cfg.slope * $signed({1'b0, cfg.half_width});

	always_ff @(posedge clk) begin
		if (en.s1) begin
			o_s1      <= o_mul;
			kw_raw_s1 <= kw_mul;
		end
	end

	assign h_raw = $signed({{(hlrc_pkg::KwRawW - hlrc_pkg::DimW - hlrc_pkg::FracW){1'b0}},
		cfg.half_height, {hlrc_pkg::FracW{1'b0}}});
	assign neg_h_raw = -h_raw;
	assign h_ext = $signed({{(hlrc_pkg::SumW - hlrc_pkg::DimW){1'b0}}, cfg.half_height});
	assign o_ext = $signed({o_s1[hlrc_pkg::OffsW-1], o_s1});

	// zero slope in sloped mode draws horizontal lines; both spare modes are vertical
	always_comb begin
		priority if (cfg.mode == hlrc_pkg::MODE_HORIZ ||
				(cfg.mode == hlrc_pkg::MODE_SLOPED && cfg.slope == '0)) begin
			kind_d = hlrc_pkg::KIND_HORIZ;
		end else if (cfg.mode != hlrc_pkg::MODE_SLOPED) begin
			kind_d = hlrc_pkg::KIND_VERT;
		end else if (!cfg.slope[hlrc_pkg::CoordW-1] && kw_raw_s1 <= h_raw) begin
			kind_d = hlrc_pkg::KIND_SHALLOW_POS;
		end else if (kw_raw_s1 > h_raw) begin
			kind_d = hlrc_pkg::KIND_STEEP_POS;
		end else if (kw_raw_s1 < neg_h_raw) begin
			kind_d = hlrc_pkg::KIND_STEEP_NEG;
		end else begin
			kind_d = hlrc_pkg::KIND_SHALLOW_NEG;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			o_s2     <= o_s1;
			kw_s2    <= $signed(kw_raw_s1[hlrc_pkg::KwRawW-1:hlrc_pkg::FracW]);
			kind_s2  <= kind_d;
			a_top_s2 <= h_ext - o_ext;
			a_bot_s2 <= -h_ext - o_ext;
		end
	end

endmodule

// ===== rtl/hlrc_isect.sv =====
// ---------------------------------------------------------------------------
// Hatch line clipper: intersection stages
// Stage 3 multiplies the top and bottom intercept operands by the inverse
// slope in two slices each; stage 4 joins the slices and compares the edge
// ordinates with the rectangle.
// ---------------------------------------------------------------------------
module hlrc_isect (
	input  logic                                  clk,
	input  hlrc_pkg::stage_en_t                   en,
	input  hlrc_pkg::cfg_t                        cfg,
	input  logic signed [hlrc_pkg::OffsW-1:0]     o_s2,
	input  logic signed [hlrc_pkg::KwW-1:0]       kw_s2,
	input  hlrc_pkg::line_kind_t                  kind_s2,
	input  logic signed [hlrc_pkg::SumW-1:0]      a_top_s2,
	input  logic signed [hlrc_pkg::SumW-1:0]      a_bot_s2,
	output logic signed [hlrc_pkg::SatInW-1:0]    top_q_s4,
	output logic signed [hlrc_pkg::SatInW-1:0]    bot_q_s4,
	output logic signed [hlrc_pkg::CoordW-1:0]    yp_sat_s4,
	output logic signed [hlrc_pkg::CoordW-1:0]    yn_sat_s4,
	output logic signed [hlrc_pkg::CoordW-1:0]    o_sat_s4,
	output hlrc_pkg::edge_flags_t                 flags_s4,
	output hlrc_pkg::line_kind_t                  kind_s4
);

	localparam int SplitW = hlrc_pkg::SplitW;
	localparam int SumW   = hlrc_pkg::SumW;
	localparam int PartW  = hlrc_pkg::PartW;
	localparam int ProdW  = hlrc_pkg::ProdW;
	localparam int SatInW = hlrc_pkg::SatInW;
	localparam int FracW  = hlrc_pkg::FracW;

	logic signed [PartW-1:0]           top_lo_s3, top_hi_s3, bot_lo_s3, bot_hi_s3;
	logic signed [SumW-1:0]            yp_s3, yn_s3;
	logic signed [hlrc_pkg::OffsW-1:0] o_s3;
	hlrc_pkg::line_kind_t              kind_s3;
	logic signed [SumW-1:0]            kw_ext, o_ext, h_ext, nh_ext;
	logic signed [ProdW-1:0]           top_p, bot_p;
	hlrc_pkg::edge_flags_t             flags_d;

	assign kw_ext = $signed({{(SumW - hlrc_pkg::KwW){kw_s2[hlrc_pkg::KwW-1]}}, kw_s2});
	assign o_ext  = $signed({o_s2[hlrc_pkg::OffsW-1], o_s2});

	always_ff @(posedge clk) begin
		if (en.s3) begin
			top_lo_s3 <= $signed({1'b0, a_top_s2[SplitW-1:0]}) * cfg.inv_slope;
			top_hi_s3 <= $signed(a_top_s2[SumW-1:SplitW]) * cfg.inv_slope;
			bot_lo_s3 <= $signed({1'b0, a_bot_s2[SplitW-1:0]}) * cfg.inv_slope;
			bot_hi_s3 <= $signed(a_bot_s2[SumW-1:SplitW]) * cfg.inv_slope;
			yp_s3     <= o_ext + kw_ext;
			yn_s3     <= o_ext - kw_ext;
			o_s3      <= o_s2;
			kind_s3   <= kind_s2;
		end
	end

	// rejoin the slices: high part weighs 2^SplitW
	assign top_p = $signed({top_hi_s3, {SplitW{1'b0}}}) +
		$signed({{(ProdW - PartW){top_lo_s3[PartW-1]}}, top_lo_s3});
	assign bot_p = $signed({bot_hi_s3, {SplitW{1'b0}}}) +
		$signed({{(ProdW - PartW){bot_lo_s3[PartW-1]}}, bot_lo_s3});

	assign h_ext  = $signed({{(SumW - hlrc_pkg::DimW){1'b0}}, cfg.half_height});
	assign nh_ext = -h_ext;

	always_comb begin
		flags_d.yp_ge_h  = yp_s3 >= h_ext;
		flags_d.yp_gt_nh = yp_s3 > nh_ext;
		flags_d.yp_lt_nh = yp_s3 < nh_ext;
		flags_d.yn_le_nh = yn_s3 <= nh_ext;
		flags_d.yn_lt_h  = yn_s3 < h_ext;
		flags_d.yn_gt_h  = yn_s3 > h_ext;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			top_q_s4  <= $signed(top_p[ProdW-1:FracW]);
			bot_q_s4  <= $signed(bot_p[ProdW-1:FracW]);
			yp_sat_s4 <= hlrc_pkg::sat_coord($signed({{(SatInW - SumW){yp_s3[SumW-1]}}, yp_s3}));
			yn_sat_s4 <= hlrc_pkg::sat_coord($signed({{(SatInW - SumW){yn_s3[SumW-1]}}, yn_s3}));
			o_sat_s4  <= hlrc_pkg::sat_coord($signed({{(SatInW - hlrc_pkg::OffsW){
				o_s3[hlrc_pkg::OffsW-1]}}, o_s3}));
			flags_s4  <= flags_d;
			kind_s4   <= kind_s3;
		end
	end

endmodule

// ===== rtl/hlrc_emit.sv =====
// ---------------------------------------------------------------------------
// Hatch line clipper: endpoint selection
// Picks the two clipped endpoints for the line kind and loads the output
// register.
// ---------------------------------------------------------------------------
module hlrc_emit (
	input  logic                                clk,
	input  hlrc_pkg::stage_en_t                 en,
	input  hlrc_pkg::cfg_t                      cfg,
	input  logic signed [hlrc_pkg::SatInW-1:0]  top_q_s4,
	input  logic signed [hlrc_pkg::SatInW-1:0]  bot_q_s4,
	input  logic signed [hlrc_pkg::CoordW-1:0]  yp_sat_s4,
	input  logic signed [hlrc_pkg::CoordW-1:0]  yn_sat_s4,
	input  logic signed [hlrc_pkg::CoordW-1:0]  o_sat_s4,
	input  hlrc_pkg::edge_flags_t               flags_s4,
	input  hlrc_pkg::line_kind_t                kind_s4,
	output logic signed [hlrc_pkg::CoordW-1:0]  x1_s5,
	output logic signed [hlrc_pkg::CoordW-1:0]  y1_s5,
	output logic signed [hlrc_pkg::CoordW-1:0]  x2_s5,
	output logic signed [hlrc_pkg::CoordW-1:0]  y2_s5
);

	logic signed [hlrc_pkg::CoordW-1:0] top_x, bot_x, w_c, nw_c, h_c, nh_c;
	logic signed [hlrc_pkg::CoordW-1:0] x1_d, y1_d, x2_d, y2_d;

	assign top_x = hlrc_pkg::sat_coord(top_q_s4);
	assign bot_x = hlrc_pkg::sat_coord(bot_q_s4);
	assign w_c   = $signed({1'b0, cfg.half_width});
	assign nw_c  = -w_c;
	assign h_c   = $signed({1'b0, cfg.half_height});
	assign nh_c  = -h_c;

	always_comb begin
		// vertical line x = o unless the kind says otherwise
		x1_d = o_sat_s4;
		y1_d = h_c;
		x2_d = o_sat_s4;
		y2_d = nh_c;
		unique case (kind_s4)
			hlrc_pkg::KIND_HORIZ: begin
				x1_d = nw_c;
				y1_d = o_sat_s4;
				x2_d = w_c;
				y2_d = o_sat_s4;
			end
			hlrc_pkg::KIND_VERT: begin
			end
			hlrc_pkg::KIND_SHALLOW_POS: begin
				x1_d = w_c;
				y1_d = yp_sat_s4;
				x2_d = nw_c;
				y2_d = yn_sat_s4;
				if (flags_s4.yp_ge_h) begin
					x1_d = top_x;
					y1_d = h_c;
				end else if (flags_s4.yn_le_nh) begin
					x2_d = bot_x;
					y2_d = nh_c;
				end
			end
			hlrc_pkg::KIND_STEEP_POS: begin
				x1_d = top_x;
				y1_d = h_c;
				x2_d = bot_x;
				y2_d = nh_c;
				if (!flags_s4.yp_ge_h) begin
					x1_d = w_c;
					y1_d = yp_sat_s4;
				end else if (!flags_s4.yn_le_nh) begin
					x2_d = nw_c;
					y2_d = yn_sat_s4;
				end
			end
			hlrc_pkg::KIND_STEEP_NEG: begin
				x1_d = top_x;
				y1_d = h_c;
				x2_d = bot_x;
				y2_d = nh_c;
				if (flags_s4.yn_lt_h) begin
					x1_d = nw_c;
					y1_d = yn_sat_s4;
				end else if (flags_s4.yp_gt_nh) begin
					x2_d = w_c;
					y2_d = yp_sat_s4;
				end
			end
			hlrc_pkg::KIND_SHALLOW_NEG: begin
				x1_d = w_c;
				y1_d = yp_sat_s4;
				x2_d = nw_c;
				y2_d = yn_sat_s4;
				if (flags_s4.yn_gt_h) begin
					x2_d = top_x;
					y2_d = h_c;
				end else if (flags_s4.yp_lt_nh) begin
					x1_d = bot_x;
					y1_d = nh_c;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			x1_s5 <= x1_d;
			y1_s5 <= y1_d;
			x2_s5 <= x2_d;
			y2_s5 <= y2_d;
		end
	end

endmodule

// ===== rtl/hatch_line_rect_clipper_core.sv =====
// ---------------------------------------------------------------------------
// Hatch line rectangle clipper
// Turns a hatch line index into the two endpoints of that line clipped to a
// rectangle centred on the origin.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / line_index) carries one request per
//   hatch line. Output channel (out_valid / out_stall / start_x, start_y,
//   end_x, end_y) returns one endpoint pair per request, in order.
//   A request is taken at a clock edge with valid high and stall low.
//   A taken request passes through the five register stages (offset multiply,
//   classify, sliced intercept multiply, join and compare, endpoint select)
//   before out_valid rises. Throughput: one request per cycle while the
//   receiver does not stall, since each stage passes one item per clock.
//   When the receiver stalls, the stalled result holds in the output register
//   and the stages behind it keep filling bubbles; in_stall rises only once
//   all five stages hold a result.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_data while no
//   request is in flight. Reset clears every stage and loads mode 0, slope and
//   inverse slope 1.0, and zero width, height and pitch.
// ---------------------------------------------------------------------------
module hatch_line_rect_clipper_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [hlrc_pkg::RegIdxW-1:0]          cfg_index,
	input  logic [hlrc_pkg::CoordW-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [hlrc_pkg::IndexW-1:0]    line_index,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [hlrc_pkg::CoordW-1:0]    start_x,
	output logic signed [hlrc_pkg::CoordW-1:0]    start_y,
	output logic signed [hlrc_pkg::CoordW-1:0]    end_x,
	output logic signed [hlrc_pkg::CoordW-1:0]    end_y
);

	logic [hlrc_pkg::ModeW-1:0]         mode_q;
	logic signed [hlrc_pkg::CoordW-1:0] slope_q, inv_slope_q;
	logic [hlrc_pkg::DimW-1:0]          half_width_q, half_height_q, line_pitch_q;
	hlrc_pkg::cfg_t                     cfg;
	hlrc_pkg::stage_en_t                en;
	logic                               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic signed [hlrc_pkg::OffsW-1:0]  o_s2;
	logic signed [hlrc_pkg::KwW-1:0]    kw_s2;
	hlrc_pkg::line_kind_t               kind_s2, kind_s4;
	logic signed [hlrc_pkg::SumW-1:0]   a_top_s2, a_bot_s2;
	logic signed [hlrc_pkg::SatInW-1:0] top_q_s4, bot_q_s4;
	logic signed [hlrc_pkg::CoordW-1:0] yp_sat_s4, yn_sat_s4, o_sat_s4;
	hlrc_pkg::edge_flags_t              flags_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= hlrc_pkg::MODE_SLOPED;
			slope_q       <= hlrc_pkg::UNITY_Q16;
			inv_slope_q   <= hlrc_pkg::UNITY_Q16;
			half_width_q  <= '0;
			half_height_q <= '0;
			line_pitch_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				hlrc_pkg::REG_MODE:      mode_q        <= cfg_data[hlrc_pkg::ModeW-1:0];
				hlrc_pkg::REG_SLOPE:     slope_q       <= cfg_data;
				hlrc_pkg::REG_INV_SLOPE: inv_slope_q   <= cfg_data;
				hlrc_pkg::REG_HALF_W:    half_width_q  <= cfg_data[hlrc_pkg::DimW-1:0];
				hlrc_pkg::REG_HALF_H:    half_height_q <= cfg_data[hlrc_pkg::DimW-1:0];
				hlrc_pkg::REG_PITCH:     line_pitch_q  <= cfg_data[hlrc_pkg::DimW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.mode        = mode_q;
		cfg.slope       = slope_q;
		cfg.inv_slope   = inv_slope_q;
		cfg.half_width  = half_width_q;
		cfg.half_height = half_height_q;
		cfg.line_pitch  = line_pitch_q;
	end

	// a stage advances when it is empty or the stage after it advances
	always_comb begin
		en.s5 = !valid_s5 || !out_stall;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_stall  = !en.s1;
	assign out_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	hlrc_front u_front (
		.clk        (clk),
		.en         (en),
		.cfg        (cfg),
		.line_index (line_index),
		.o_s2       (o_s2),
		.kw_s2      (kw_s2),
		.kind_s2    (kind_s2),
		.a_top_s2   (a_top_s2),
		.a_bot_s2   (a_bot_s2)
	);

	hlrc_isect u_isect (
		.clk       (clk),
		.en        (en),
		.cfg       (cfg),
		.o_s2      (o_s2),
		.kw_s2     (kw_s2),
		.kind_s2   (kind_s2),
		.a_top_s2  (a_top_s2),
		.a_bot_s2  (a_bot_s2),
		.top_q_s4  (top_q_s4),
		.bot_q_s4  (bot_q_s4),
		.yp_sat_s4 (yp_sat_s4),
		.yn_sat_s4 (yn_sat_s4),
		.o_sat_s4  (o_sat_s4),
		.flags_s4  (flags_s4),
		.kind_s4   (kind_s4)
	);

	hlrc_emit u_emit (
		.clk       (clk),
		.en        (en),
		.cfg       (cfg),
		.top_q_s4  (top_q_s4),
		.bot_q_s4  (bot_q_s4),
		.yp_sat_s4 (yp_sat_s4),
		.yn_sat_s4 (yn_sat_s4),
		.o_sat_s4  (o_sat_s4),
		.flags_s4  (flags_s4),
		.kind_s4   (kind_s4),
		.x1_s5     (start_x),
		.y1_s5     (start_y),
		.x2_s5     (end_x),
		.y2_s5     (end_y)
	);

`ifndef ASSERT_OFF
	// back-pressure reaches the input only with every stage occupied
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && out_stall))
		else $error("input stalled with a free pipeline stage");

	// requests in flight change only by what enters and leaves
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5}) ==
			$countones($past({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5})) +
			$past(in_valid && !in_stall) - $past(out_valid && !out_stall)))
		else $error("request lost or duplicated in pipeline");

	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("taken request missing from first stage");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !en.s2) |=> valid_s2)
		else $error("held stage two request dropped");
`endif

endmodule

// ===== verif/hatch_line_rect_clipper_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hatch line rectangle clipper testbench
// Sends line index requests through a table of directed cases and then through
// random phases, each with its own register setting. Every endpoint pair that
// comes back is compared with a clipping predictor kept inside the bench.
// ----------------------------------------------------------------------------
module hatch_line_rect_clipper_core_tb;

	localparam int CoordW  = hlrc_pkg::CoordW;
	localparam int DimW    = hlrc_pkg::DimW;
	localparam int IndexW  = hlrc_pkg::IndexW;
	localparam int FracW   = hlrc_pkg::FracW;
	localparam int ModeW   = hlrc_pkg::ModeW;
	localparam int RegIdxW = hlrc_pkg::RegIdxW;

	localparam logic [ModeW-1:0]   MODE_VERT    = 2'd2;
	localparam logic [ModeW-1:0]   MODE_SPARE   = 2'd3;
	localparam logic [RegIdxW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [RegIdxW-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [DimW-1:0]          DIM_MAX   = '1;
	localparam logic signed [IndexW-1:0] INDEX_MIN = 16'sh8000;
	localparam logic signed [IndexW-1:0] INDEX_MAX = 16'sh7fff;
	localparam int     UNIT      = 65536;
	localparam int     COORD_MAX = 32'sh7fff_ffff;
	localparam int     COORD_MIN = 32'sh8000_0000;
	localparam longint PROD_CAP  = 64'sd1 <<< 62;

	localparam int PHASES          = 16;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int CYCLE_LIMIT     = 500000;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic signed [CoordW-1:0] sx, sy, ex, ey;
	} ends_t;

	typedef struct packed {
		hlrc_pkg::cfg_t           cfg;
		logic signed [IndexW-1:0] idx;
		logic                     typed;
		ends_t                    ends;
	} row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BEAT
	} stall_style_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     cfg_wr_en  = 1'b0;
	logic [RegIdxW-1:0]       cfg_index  = '0;
	logic [CoordW-1:0]        cfg_data   = '0;
	logic                     in_valid   = 1'b0;
	logic                     in_stall;
	logic signed [IndexW-1:0] line_index = '0;
	logic                     out_valid;
	logic                     out_stall  = 1'b0;
	logic signed [CoordW-1:0] start_x, start_y, end_x, end_y;

	hlrc_pkg::cfg_t cfg_now;
	ends_t          pending_ends[$];
	ends_t          want_ends;
	row_t           directed_rows[$];
	int             error_count = 0;
	stall_style_t   stall_style = STALL_NONE;
	int             style_left  = 0;

	hatch_line_rect_clipper_core i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor(a * b / 2^16), magnitude held to 2^62
	function automatic longint q16_product(longint a, longint b);
		wide_t wa, wb, p;
		wa = a;
		wb = b;
		p = (wa * wb) >>> FracW;
		if (p > PROD_CAP) begin
			p = PROD_CAP;
		end else if (p < -PROD_CAP) begin
			p = -PROD_CAP;
		end
		return longint'(p);
	endfunction

	function automatic logic signed [CoordW-1:0] clamp_coord(longint v);
		if (v > COORD_MAX) begin
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			return COORD_MIN;
		end
		return v[CoordW-1:0];
	endfunction

	function automatic ends_t clip_line(logic signed [IndexW-1:0] idx);
		longint w, h, k, inv, o, kw_raw, h_raw, kw, top_x, bot_x;
		longint x1, y1, x2, y2;
		ends_t  r;
		w   = cfg_now.half_width;
		h   = cfg_now.half_height;
		k   = $signed(cfg_now.slope);
		inv = $signed(cfg_now.inv_slope);
		o   = longint'(cfg_now.line_pitch) * longint'(idx);
		if (cfg_now.mode == hlrc_pkg::MODE_HORIZ ||
				(cfg_now.mode == hlrc_pkg::MODE_SLOPED && k == 0)) begin
			x1 = -w; y1 = o; x2 = w; y2 = o;
		end else if (cfg_now.mode == MODE_VERT || cfg_now.mode == MODE_SPARE) begin
			x1 = o; y1 = h; x2 = o; y2 = -h;
		end else begin
			kw_raw = k * w;
			h_raw  = h * UNIT;
			kw     = q16_product(k, w);
			top_x  = q16_product(h - o, inv);
			bot_x  = q16_product(-h - o, inv);
			if (k > 0 && kw_raw <= h_raw) begin
				x1 = w; y1 = kw + o; x2 = -w; y2 = -kw + o;
				if (o >= h - kw) begin
					x1 = top_x; y1 = h;
				end else if (o <= kw - h) begin
					x2 = bot_x; y2 = -h;
				end
			end else if (kw_raw > h_raw) begin
				x1 = top_x; y1 = h; x2 = bot_x; y2 = -h;
				if (o < h - kw) begin
					x1 = w; y1 = kw + o;
				end else if (o > kw - h) begin
					x2 = -w; y2 = -kw + o;
				end
			end else if (kw_raw < -h_raw) begin
				x1 = top_x; y1 = h; x2 = bot_x; y2 = -h;
				if (o < h + kw) begin
					x1 = -w; y1 = -kw + o;
				end else if (o > -h - kw) begin
					x2 = w; y2 = kw + o;
				end
			end else begin
				x1 = w; y1 = kw + o; x2 = -w; y2 = -kw + o;
				if (o > h + kw) begin
					x2 = top_x; y2 = h;
				end else if (o < -h - kw) begin
					x1 = bot_x; y1 = -h;
				end
			end
		end
		r.sx = clamp_coord(x1);
		r.sy = clamp_coord(y1);
		r.ex = clamp_coord(x2);
		r.ey = clamp_coord(y2);
		return r;
	endfunction

	function automatic hlrc_pkg::cfg_t make_cfg(logic [ModeW-1:0] mode,
		logic signed [CoordW-1:0] slope, logic signed [CoordW-1:0] inv_slope,
		logic [DimW-1:0] w, logic [DimW-1:0] h, logic [DimW-1:0] pitch);
		hlrc_pkg::cfg_t c;
		c.mode        = mode;
		c.slope       = slope;
		c.inv_slope   = inv_slope;
		c.half_width  = w;
		c.half_height = h;
		c.line_pitch  = pitch;
		return c;
	endfunction

	function automatic void add_row(hlrc_pkg::cfg_t c, logic signed [IndexW-1:0] idx,
		logic typed, int sx, int sy, int ex, int ey);
		row_t r;
		r.cfg     = c;
		r.idx     = idx;
		r.typed   = typed;
		r.ends.sx = sx;
		r.ends.sy = sy;
		r.ends.ex = ex;
		r.ends.ey = ey;
		directed_rows.push_back(r);
	endfunction

	function automatic logic [DimW-1:0] pick_dim(int top);
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIM_MAX;
			2: return raw[DimW-1:0];
			default: return $urandom_range(1, top);
		endcase
	endfunction

	function automatic hlrc_pkg::cfg_t pick_config();
		hlrc_pkg::cfg_t c;
		int             sel;
		int             mag;
		longint         k;
		sel = $urandom_range(0, 9);
		case (sel)
			6: c.mode = hlrc_pkg::MODE_HORIZ;
			7: c.mode = MODE_VERT;
			8: c.mode = MODE_SPARE;
			default: c.mode = hlrc_pkg::MODE_SLOPED;
		endcase
		case ($urandom_range(0, 9))
			0: c.slope = 32'sh7fff_ffff;
			1: c.slope = 32'sh8000_0000;
			2: c.slope = $urandom();
			default: begin
				mag = $urandom_range(3277, 20 * UNIT);
				c.slope = $urandom_range(0, 1) ? -mag : mag;
			end
		endcase
		if (sel == 9) begin
			c.slope = '0;
		end
		k = $signed(c.slope);
		// mostly a matching reciprocal, now and then an unrelated one
		if ($urandom_range(0, 4) != 0 && k != 0) begin
			c.inv_slope = (64'sd1 <<< 32) / k;
		end else begin
			c.inv_slope = $urandom();
		end
		c.half_width  = pick_dim(200 * UNIT);
		c.half_height = pick_dim(200 * UNIT);
		c.line_pitch  = pick_dim(8 * UNIT);
		return c;
	endfunction

	function automatic logic signed [IndexW-1:0] pick_index(int span);
		int          v;
		logic [31:0] raw;
		raw = $urandom();
		v   = $urandom_range(0, 2 * span);
		case ($urandom_range(0, 19))
			14, 15, 16: return raw[IndexW-1:0];
			17: return INDEX_MIN;
			18: return INDEX_MAX;
			19: return $urandom_range(0, 2) - 1;
			default: return v - span;
		endcase
	endfunction

	task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CoordW-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			hlrc_pkg::REG_MODE:      cfg_now.mode        = data[ModeW-1:0];
			hlrc_pkg::REG_SLOPE:     cfg_now.slope       = data;
			hlrc_pkg::REG_INV_SLOPE: cfg_now.inv_slope   = data;
			hlrc_pkg::REG_HALF_W:    cfg_now.half_width  = data[DimW-1:0];
			hlrc_pkg::REG_HALF_H:    cfg_now.half_height = data[DimW-1:0];
			hlrc_pkg::REG_PITCH:     cfg_now.line_pitch  = data[DimW-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// unused upper bits carry junk, which the block must drop
	task automatic load_config(input hlrc_pkg::cfg_t c);
		logic [31:0] junk;
		junk = $urandom();
		write_reg(hlrc_pkg::REG_MODE, {junk[31:ModeW], c.mode});
		write_reg(hlrc_pkg::REG_SLOPE, c.slope);
		write_reg(hlrc_pkg::REG_INV_SLOPE, c.inv_slope);
		write_reg(hlrc_pkg::REG_HALF_W, {junk[0], c.half_width});
		write_reg(hlrc_pkg::REG_HALF_H, {junk[1], c.half_height});
		write_reg(hlrc_pkg::REG_PITCH, {junk[2], c.line_pitch});
		write_reg(REG_SPARE_LO, junk);
		write_reg(REG_SPARE_HI, ~junk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_ends.size() != 0) begin
			@(negedge clk);
		end
		repeat (6) @(negedge clk);
	endtask

	task automatic gap_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// hold the request until it is taken, then queue its endpoints
	task automatic push_request(input logic signed [IndexW-1:0] idx, input ends_t expected);
		in_valid   <= 1'b1;
		line_index <= idx;
		do begin
			@(posedge clk);
		end while (in_stall);
		pending_ends.push_back(expected);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (style_left == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			style_left  <= $urandom_range(20, 200);
		end else begin
			style_left <= style_left - 1;
		end
		case (stall_style)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= style_left[2];
		endcase
	end

	function automatic void check_field(string name, logic signed [CoordW-1:0] want,
		logic signed [CoordW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ends.size() == 0) begin
				$error("endpoints returned with no request outstanding");
				error_count++;
			end else begin
				want_ends = pending_ends.pop_front();
				check_field("start_x", want_ends.sx, start_x);
				check_field("start_y", want_ends.sy, start_y);
				check_field("end_x", want_ends.ex, end_x);
				check_field("end_y", want_ends.ey, end_y);
			end
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		hlrc_pkg::cfg_t c_reset, c_horiz, c_horiz_max, c_vert, c_spare, c_flat;
		hlrc_pkg::cfg_t c_shallow_pos, c_steep_pos, c_steep_neg, c_shallow_neg;
		hlrc_pkg::cfg_t c_edge_pos, c_edge_neg;
		row_t           row;
		int             burst_left;
		longint         k_abs, reach, span;
		logic signed [IndexW-1:0] idx;

		c_reset       = make_cfg(hlrc_pkg::MODE_SLOPED, hlrc_pkg::UNITY_Q16,
			hlrc_pkg::UNITY_Q16, '0, '0, '0);
		c_horiz       = make_cfg(hlrc_pkg::MODE_HORIZ, hlrc_pkg::UNITY_Q16,
			hlrc_pkg::UNITY_Q16, 10 * UNIT, 5 * UNIT, UNIT);
		c_horiz_max   = make_cfg(hlrc_pkg::MODE_HORIZ, hlrc_pkg::UNITY_Q16,
			hlrc_pkg::UNITY_Q16, DIM_MAX, '0, DIM_MAX);
		c_vert        = make_cfg(MODE_VERT, hlrc_pkg::UNITY_Q16, hlrc_pkg::UNITY_Q16,
			10 * UNIT, 5 * UNIT, UNIT);
		c_spare       = make_cfg(MODE_SPARE, hlrc_pkg::UNITY_Q16, hlrc_pkg::UNITY_Q16,
			10 * UNIT, 5 * UNIT, UNIT);
		c_flat        = make_cfg(hlrc_pkg::MODE_SLOPED, '0, hlrc_pkg::UNITY_Q16,
			10 * UNIT, 5 * UNIT, UNIT);
		c_shallow_pos = make_cfg(hlrc_pkg::MODE_SLOPED, UNIT / 2, 2 * UNIT,
			10 * UNIT, 8 * UNIT, UNIT);
		c_steep_pos   = make_cfg(hlrc_pkg::MODE_SLOPED, 2 * UNIT, UNIT / 2,
			10 * UNIT, 5 * UNIT, UNIT);
		c_steep_neg   = make_cfg(hlrc_pkg::MODE_SLOPED, -2 * UNIT, -UNIT / 2,
			10 * UNIT, 5 * UNIT, UNIT);
		c_shallow_neg = make_cfg(hlrc_pkg::MODE_SLOPED, -UNIT / 2, -2 * UNIT,
			10 * UNIT, 8 * UNIT, UNIT);
		c_edge_pos    = make_cfg(hlrc_pkg::MODE_SLOPED, 32'sh7fff_ffff, 32'sh8000_0000,
			DIM_MAX, DIM_MAX, DIM_MAX);
		c_edge_neg    = make_cfg(hlrc_pkg::MODE_SLOPED, 32'sh8000_0000, 32'sh7fff_ffff,
			DIM_MAX, DIM_MAX, DIM_MAX);

		// registers as left by reset: zero-sized rectangle, zero pitch
		add_row(c_reset, 0, 1'b1, 0, 0, 0, 0);
		add_row(c_reset, INDEX_MAX, 1'b1, 0, 0, 0, 0);
		add_row(c_horiz, 3, 1'b1, -10 * UNIT, 3 * UNIT, 10 * UNIT, 3 * UNIT);
		add_row(c_horiz, INDEX_MIN, 1'b1, -10 * UNIT, COORD_MIN, 10 * UNIT, COORD_MIN);
		add_row(c_horiz_max, INDEX_MAX, 1'b1, -COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		add_row(c_horiz_max, INDEX_MIN, 1'b1, -COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
		add_row(c_vert, -4, 1'b1, -4 * UNIT, 5 * UNIT, -4 * UNIT, -5 * UNIT);
		add_row(c_spare, -4, 1'b1, -4 * UNIT, 5 * UNIT, -4 * UNIT, -5 * UNIT);
		add_row(c_flat, 2, 1'b1, -10 * UNIT, 2 * UNIT, 10 * UNIT, 2 * UNIT);
		add_row(c_shallow_pos, 0, 1'b0, 0, 0, 0, 0);
		add_row(c_shallow_pos, 4, 1'b0, 0, 0, 0, 0);
		add_row(c_shallow_pos, -4, 1'b0, 0, 0, 0, 0);
		add_row(c_steep_pos, 0, 1'b0, 0, 0, 0, 0);
		add_row(c_steep_pos, -20, 1'b0, 0, 0, 0, 0);
		add_row(c_steep_pos, 20, 1'b0, 0, 0, 0, 0);
		add_row(c_steep_neg, 0, 1'b0, 0, 0, 0, 0);
		add_row(c_steep_neg, -20, 1'b0, 0, 0, 0, 0);
		add_row(c_steep_neg, 20, 1'b0, 0, 0, 0, 0);
		add_row(c_shallow_neg, 0, 1'b0, 0, 0, 0, 0);
		add_row(c_shallow_neg, 4, 1'b0, 0, 0, 0, 0);
		add_row(c_shallow_neg, -4, 1'b0, 0, 0, 0, 0);
		add_row(c_edge_pos, INDEX_MAX, 1'b0, 0, 0, 0, 0);
		add_row(c_edge_pos, INDEX_MIN, 1'b0, 0, 0, 0, 0);
		add_row(c_edge_neg, INDEX_MIN, 1'b0, 0, 0, 0, 0);

		cfg_now = c_reset;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.cfg != cfg_now) begin
				wait_drained();
				load_config(row.cfg);
			end
			push_request(row.idx, row.typed ? row.ends : clip_line(row.idx));
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			load_config(pick_config());

			// aim the indices at offsets around the rectangle's reach
			k_abs = $signed(cfg_now.slope);
			if (k_abs < 0) begin
				k_abs = -k_abs;
			end
			if (cfg_now.mode == hlrc_pkg::MODE_SLOPED) begin
				reach = longint'(cfg_now.half_height)
					+ ((k_abs * longint'(cfg_now.half_width)) >>> FracW);
			end else if (cfg_now.mode == hlrc_pkg::MODE_HORIZ) begin
				reach = cfg_now.half_height;
			end else begin
				reach = cfg_now.half_width;
			end
			if (cfg_now.line_pitch == '0) begin
				span = INDEX_MAX;
			end else begin
				span = reach / longint'(cfg_now.line_pitch) + 2;
			end
			if (span > INDEX_MAX) begin
				span = INDEX_MAX;
			end

			burst_left = $urandom_range(1, 24);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (burst_left == 0) begin
					if ($urandom_range(0, 2) != 0) begin
						gap_cycles($urandom_range(1, 8));
					end
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				idx = pick_index(int'(span));
				push_request(idx, clip_line(idx));
			end
		end

		wait_drained();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
